// File: rtl/bitmap_font_text_quad_generator_assert.svh
// assertion macros for the bitmap font text quad generator checker
`ifndef BITMAP_FONT_TEXT_QUAD_GENERATOR_ASSERT_SVH
`define BITMAP_FONT_TEXT_QUAD_GENERATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define BFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BFQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bfq_pkg.sv
// package with shared types and constants of the text quad generator
`timescale 1ns / 1ps
`default_nettype none

package bfq_pkg;

    localparam int TAB_STOP_DEFAULT = 4;

    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 16;
    localparam int POS_W    = 24;
    localparam int TEX_W    = 26;
    localparam int CORNER_W = 2;
    localparam int SIZE_W   = 8;
    localparam int GRID_W   = 9;
    localparam int SCALE_W  = 18;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 18;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 120;

    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = POS_X_LSB + POS_W;
    localparam int TEX_U_LSB   = POS_Y_LSB + POS_W;
    localparam int TEX_V_LSB   = TEX_U_LSB + TEX_W;
    localparam int CORNER_LSB  = TEX_V_LSB + TEX_W;
    localparam int QUAD_LSB    = CORNER_LSB + CORNER_W;
    localparam int PACKED_W    = QUAD_LSB + CNT_W;

    localparam logic [CFG_IW-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CHAR_OFFSET  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GRID_COLUMNS = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_GRID_ROWS    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_UV_SCALE_U   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_UV_SCALE_V   = 3'd6;

    localparam logic [SIZE_W-1:0]  RST_GLYPH_WIDTH  = 8'd8;
    localparam logic [SIZE_W-1:0]  RST_GLYPH_HEIGHT = 8'd8;
    localparam logic [CHAR_W-1:0]  RST_CHAR_OFFSET  = 8'd32;
    localparam logic [GRID_W-1:0]  RST_GRID_COLUMNS = 9'd16;
    localparam logic [GRID_W-1:0]  RST_GRID_ROWS    = 9'd16;
    localparam logic [SCALE_W-1:0] RST_UV_SCALE_U   = 18'd8224;
    localparam logic [SCALE_W-1:0] RST_UV_SCALE_V   = 18'd8224;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul;
        logic emit;
    } bfq_cmd_t;

    typedef struct packed {
        logic printable;
        logic div_done;
        logic out_free;
        logic last_corner;
    } bfq_stat_t;

endpackage

`default_nettype wire

// File: rtl/bfq_div.sv
// radix-4 restoring divider splitting the atlas cell into row and column
`timescale 1ns / 1ps
`default_nettype none

module bfq_div
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             step,
    input  wire logic [bfq_pkg::CHAR_W-1:0]       dividend,
    input  wire logic [bfq_pkg::GRID_W-1:0]       divisor,
    output logic      [bfq_pkg::CHAR_W-1:0]       quotient,
    output logic      [bfq_pkg::GRID_W-1:0]       remainder,
    output logic                                  done
);

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = bfq_pkg::CHAR_W / BITS_PER_STEP;
    localparam int CW            = $clog2(STEPS);

    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_next;
    logic [bfq_pkg::CHAR_W-1:0]     quo_reg;
    logic [bfq_pkg::CHAR_W-1:0]     quo_next;
    logic [bfq_pkg::GRID_W-1:0]     rem_reg;
    logic [bfq_pkg::GRID_W-1:0]     rem_next;

    always_comb
    begin
        logic [bfq_pkg::GRID_W:0]   trial;
        logic [bfq_pkg::CHAR_W-1:0] q;
        logic [bfq_pkg::GRID_W-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial = {r, q[bfq_pkg::CHAR_W-1]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
                q     = {q[bfq_pkg::CHAR_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[bfq_pkg::CHAR_W-2:0], 1'b0};
            end
            r = trial[bfq_pkg::GRID_W-1:0];
        end
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            quo_next = q;
            rem_next = r;
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = (cnt_reg == CW'(STEPS - 1));

endmodule

`default_nettype wire

// File: rtl/bfq_dp.sv
// datapath: registers, text counters, cell split, vertex build and output register
`timescale 1ns / 1ps
`default_nettype none

module bfq_dp
#(
    parameter int TAB_STOP = bfq_pkg::TAB_STOP_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bfq_pkg::CFG_IW-1:0]          cfg_index,
    input  wire logic [bfq_pkg::CFG_DW-1:0]          cfg_data,
    input  wire logic [bfq_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [bfq_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    input  wire bfq_pkg::bfq_cmd_t                   cmd,
    output bfq_pkg::bfq_stat_t                       stat
);

    localparam int MW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CW = bfq_pkg::CNT_W;
    localparam int MOD_AT_MAX_I = 65535 % TAB_STOP;
    localparam logic [MW-1:0] MOD_AT_MAX = MW'(MOD_AT_MAX_I);
    localparam logic [MW-1:0] MOD_LAST   = MW'(TAB_STOP - 1);
    localparam logic [CW-1:0] CNT_MAX    = '1;

    logic [bfq_pkg::SIZE_W-1:0]  gw_reg;
    logic [bfq_pkg::SIZE_W-1:0]  gh_reg;
    logic [bfq_pkg::CHAR_W-1:0]  off_reg;
    logic [bfq_pkg::GRID_W-1:0]  gc_reg;
    logic [bfq_pkg::GRID_W-1:0]  gr_reg;
    logic [bfq_pkg::SCALE_W-1:0] su_reg;
    logic [bfq_pkg::SCALE_W-1:0] sv_reg;

    logic [CW-1:0] line_reg;
    logic [CW-1:0] line_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [MW-1:0] mod_reg;
    logic [MW-1:0] mod_next;
    logic [CW-1:0] quad_reg;
    logic [CW-1:0] quad_next;

    logic [CW-1:0] line_c;
    logic [CW-1:0] col_c;
    logic [MW-1:0] mod_c;
    logic [CW-1:0] quad_c;
    logic [CW:0]   tab_sum;

    logic [bfq_pkg::CHAR_W-1:0]  div_quo;
    logic [bfq_pkg::GRID_W-1:0]  div_rem;
    logic [bfq_pkg::GRID_W-1:0]  divisor;
    logic                        div_done;
    logic                        printable;

    logic [bfq_pkg::CHAR_W-1:0]  acol;
    logic                        outside;
    logic [bfq_pkg::GRID_W-1:0]  arow_full;
    logic [bfq_pkg::GRID_W-1:0]  arow;

    logic [bfq_pkg::POS_W-1:0]   bx_reg;
    logic [bfq_pkg::POS_W-1:0]   by_reg;
    logic [bfq_pkg::TEX_W-1:0]   tu0_reg;
    logic [bfq_pkg::TEX_W-1:0]   tv0_reg;
    logic [CW-1:0]               qn_reg;
    logic                        outside_reg;
    logic [bfq_pkg::CORNER_W-1:0] corner_reg;

    logic                        right;
    logic                        bottom;

    logic                        out_valid_reg;
    logic [bfq_pkg::POS_W-1:0]   px_reg;
    logic [bfq_pkg::POS_W-1:0]   py_reg;
    logic [bfq_pkg::TEX_W-1:0]   tu_reg;
    logic [bfq_pkg::TEX_W-1:0]   tv_reg;
    logic [bfq_pkg::CORNER_W-1:0] oc_reg;
    logic [CW-1:0]               oq_reg;
    logic                        oo_reg;
    logic                        ol_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= bfq_pkg::RST_GLYPH_WIDTH;
            gh_reg  <= bfq_pkg::RST_GLYPH_HEIGHT;
            off_reg <= bfq_pkg::RST_CHAR_OFFSET;
            gc_reg  <= bfq_pkg::RST_GRID_COLUMNS;
            gr_reg  <= bfq_pkg::RST_GRID_ROWS;
            su_reg  <= bfq_pkg::RST_UV_SCALE_U;
            sv_reg  <= bfq_pkg::RST_UV_SCALE_V;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfq_pkg::CFG_GLYPH_WIDTH:  gw_reg  <= cfg_data[bfq_pkg::SIZE_W-1:0];
                bfq_pkg::CFG_GLYPH_HEIGHT: gh_reg  <= cfg_data[bfq_pkg::SIZE_W-1:0];
                bfq_pkg::CFG_CHAR_OFFSET:  off_reg <= cfg_data[bfq_pkg::CHAR_W-1:0];
                bfq_pkg::CFG_GRID_COLUMNS: gc_reg  <= cfg_data[bfq_pkg::GRID_W-1:0];
                bfq_pkg::CFG_GRID_ROWS:    gr_reg  <= cfg_data[bfq_pkg::GRID_W-1:0];
                bfq_pkg::CFG_UV_SCALE_U:   su_reg  <= cfg_data[bfq_pkg::SCALE_W-1:0];
                bfq_pkg::CFG_UV_SCALE_V:   sv_reg  <= cfg_data[bfq_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // text counters, column kept together with its position between tab stops
    assign line_c  = s_tuser ? '0 : line_reg;
    assign col_c   = s_tuser ? '0 : col_reg;
    assign mod_c   = s_tuser ? '0 : mod_reg;
    assign quad_c  = s_tuser ? '0 : quad_reg;
    assign tab_sum = {1'b0, col_c} + (17'(TAB_STOP) - 17'(mod_c));

    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        mod_next  = mod_reg;
        quad_next = quad_reg;
        if (cmd.accept)
        begin
            line_next = line_c;
            col_next  = col_c;
            mod_next  = mod_c;
            quad_next = quad_c;
            case (s_tdata)
                bfq_pkg::CHAR_TAB:
                begin
                    if (tab_sum[CW])
                    begin
                        col_next = CNT_MAX;
                        mod_next = MOD_AT_MAX;
                    end
                    else
                    begin
                        col_next = tab_sum[CW-1:0];
                        mod_next = '0;
                    end
                end
                bfq_pkg::CHAR_LF:
                begin
                    line_next = (line_c == CNT_MAX) ? CNT_MAX : line_c + CW'(1);
                    col_next  = '0;
                    mod_next  = '0;
                end
                default: ;
            endcase
        end
        else if (cmd.mul)
        begin
            if (col_reg != CNT_MAX)
            begin
                col_next = col_reg + CW'(1);
                mod_next = (mod_reg == MOD_LAST) ? '0 : mod_reg + MW'(1);
            end
            quad_next = (quad_reg == CNT_MAX) ? CNT_MAX : quad_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            col_reg  <= '0;
            mod_reg  <= '0;
            quad_reg <= '0;
        end
        else
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            mod_reg  <= mod_next;
            quad_reg <= quad_next;
        end
    end

    // atlas cell split into row index and column
    assign printable = (s_tdata != bfq_pkg::CHAR_NUL) && (s_tdata != bfq_pkg::CHAR_TAB)
                    && (s_tdata != bfq_pkg::CHAR_LF) && (s_tdata != bfq_pkg::CHAR_CR);
    assign divisor   = (gc_reg == '0) ? bfq_pkg::GRID_W'(1) : gc_reg;

    bfq_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.accept && printable),
        .step      (cmd.div_step),
        .dividend  (s_tdata - off_reg),
        .divisor   (divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign acol      = div_rem[bfq_pkg::CHAR_W-1:0];
    assign outside   = ({1'b0, div_quo} >= gr_reg);
    assign arow_full = gr_reg - {1'b0, div_quo} - bfq_pkg::GRID_W'(1);
    assign arow      = outside ? '0 : arow_full;

    // per-glyph base values
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            bx_reg      <= bfq_pkg::POS_W'(col_reg) * bfq_pkg::POS_W'(gw_reg);
            by_reg      <= bfq_pkg::POS_W'(line_reg) * bfq_pkg::POS_W'(gh_reg);
            tu0_reg     <= bfq_pkg::TEX_W'(acol) * bfq_pkg::TEX_W'(su_reg);
            tv0_reg     <= bfq_pkg::TEX_W'(arow) * bfq_pkg::TEX_W'(sv_reg);
            qn_reg      <= quad_reg;
            outside_reg <= outside;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= bfq_pkg::CORNER_TL;
        end
        else if (cmd.mul)
        begin
            corner_reg <= bfq_pkg::CORNER_TL;
        end
        else if (cmd.emit)
        begin
            corner_reg <= corner_reg + bfq_pkg::CORNER_W'(1);
        end
    end

    // output register
    assign right  = (corner_reg == bfq_pkg::CORNER_TR) || (corner_reg == bfq_pkg::CORNER_BR);
    assign bottom = (corner_reg == bfq_pkg::CORNER_BR) || (corner_reg == bfq_pkg::CORNER_BL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            px_reg <= right  ? bx_reg + bfq_pkg::POS_W'(gw_reg) : bx_reg;
            py_reg <= bottom ? by_reg + bfq_pkg::POS_W'(gh_reg) : by_reg;
            tu_reg <= right  ? tu0_reg + bfq_pkg::TEX_W'(su_reg) : tu0_reg;
            tv_reg <= bottom ? tv0_reg + bfq_pkg::TEX_W'(sv_reg) : tv0_reg;
            oc_reg <= corner_reg;
            oq_reg <= qn_reg;
            oo_reg <= outside_reg;
            ol_reg <= (corner_reg == bfq_pkg::CORNER_BL);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(bfq_pkg::M_TDATA_W - bfq_pkg::PACKED_W)'(0),
                       oq_reg, oc_reg, tv_reg, tu_reg, py_reg, px_reg};
    assign m_tuser  = oo_reg;
    assign m_tlast  = ol_reg;

    assign stat.printable   = printable;
    assign stat.div_done    = div_done;
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.last_corner = (corner_reg == bfq_pkg::CORNER_BL);

endmodule

`default_nettype wire

// File: rtl/bfq_ctrl.sv
// controller state machine sequencing accept, divide, multiply and vertex output
`timescale 1ns / 1ps
`default_nettype none

module bfq_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire bfq_pkg::bfq_stat_t  stat,
    output bfq_pkg::bfq_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.mul      = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && stat.printable)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free && stat.last_corner)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bitmap_font_text_quad_generator.sv
// top level of the bitmap font text quad generator
// control bytes (nul, tab, line feed, carriage return) are taken without leaving idle
// a printable byte runs accept, 4 radix-4 divider steps, multiply, then 4 vertices
// and blocks new bytes; each vertex waits while the single output register is stalled
// first vertex is valid after byte transfer, the divider steps, multiply and emit states
// rst_n clears counters and handshakes at once and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module bitmap_font_text_quad_generator
#(
    parameter int TAB_STOP = bfq_pkg::TAB_STOP_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bfq_pkg::CFG_IW-1:0]      cfg_index,
    input  wire logic [bfq_pkg::CFG_DW-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bfq_pkg::S_TDATA_W-1:0]   s_tdata,  // char_code
    input  wire logic                            s_tuser,  // start_text
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pos_x, pos_y, tex_u, tex_v, corner, quad_number, zero fill
    output logic      [bfq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tuser,  // outside_atlas
    output logic                                 m_tlast
);

    bfq_pkg::bfq_cmd_t  cmd;
    bfq_pkg::bfq_stat_t stat;

    bfq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfq_dp
    #(
        .TAB_STOP (TAB_STOP)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: rtl/bfq_checker.sv
// port-level assertion checker for the text quad generator, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_font_text_quad_generator_assert.svh"

module bfq_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [bfq_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tlast
);

    logic [bfq_pkg::CORNER_W-1:0] corner;
    logic [bfq_pkg::CNT_W-1:0]    quad;
    logic                         out_stall;
    logic                         out_mid;
    logic                         mid_glyph;
    logic                         is_bl;
    logic                         next_ok;
    logic [bfq_pkg::CORNER_W-1:0] corner_after_reg;
    logic [bfq_pkg::CNT_W-1:0]    quad_prev_reg;

    assign corner    = m_tdata[bfq_pkg::CORNER_LSB +: bfq_pkg::CORNER_W];
    assign quad      = m_tdata[bfq_pkg::QUAD_LSB +: bfq_pkg::CNT_W];
    assign out_stall = m_tvalid && !m_tready;
    assign out_mid   = m_tvalid && !m_tlast;
    assign mid_glyph = out_mid && m_tready;
    assign is_bl     = (corner == bfq_pkg::CORNER_BL);
    assign next_ok   = m_tvalid && (corner == corner_after_reg) && (quad == quad_prev_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_after_reg <= '0;
            quad_prev_reg    <= '0;
        end
        else
        begin
            corner_after_reg <= corner + bfq_pkg::CORNER_W'(1);
            quad_prev_reg    <= quad;
        end
    end

    `BFQ_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "stalled vertex changed")
    `BFQ_ASSERT(a_last_corner, m_tvalid |-> (m_tlast == is_bl), "last flag off the last corner")
    `BFQ_ASSERT(a_next_corner, mid_glyph |=> next_ok, "glyph vertices not back to back")
    `BFQ_ASSERT(a_no_accept_mid, out_mid |-> !s_tready, "byte taken while glyph pending")
    `BFQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind bitmap_font_text_quad_generator bfq_checker u_bfq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: sim/bfq_checker.sv
// checker that predicts the vertex stream of the text quad generator and compares it
`timescale 1ns / 1ps

module bfq_tb_checker
#(
    parameter int TAB_STOP = bfq_pkg::TAB_STOP_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bfq_pkg::CFG_IW-1:0]      cfg_index,
    input  wire logic [bfq_pkg::CFG_DW-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [bfq_pkg::S_TDATA_W-1:0]   s_tdata,  // char_code
    input  wire logic                            s_tuser,  // start_text
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // pos_x, pos_y, tex_u, tex_v, corner, quad_number, zero fill
    input  wire logic [bfq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            m_tuser,  // outside_atlas
    input  wire logic                            m_tlast,
    output int                                   fail_count,
    output int                                   pending
);

    import bfq_pkg::*;

    localparam int BUF_DEPTH = 256;
    localparam logic [31:0] POS_LIMIT = 32'hFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
        logic [CORNER_W-1:0] corner;
        logic [CNT_W-1:0]    quad;
        logic                outside;
        logic                last;
    } vertex_t;

    vertex_t vertex_buf[BUF_DEPTH];

    logic [SIZE_W-1:0]  glyph_w;
    logic [SIZE_W-1:0]  glyph_h;
    logic [CHAR_W-1:0]  char_off;
    logic [GRID_W-1:0]  grid_cols;
    logic [GRID_W-1:0]  grid_rows;
    logic [SCALE_W-1:0] scale_u;
    logic [SCALE_W-1:0] scale_v;

    logic [CNT_W-1:0] line_cnt;
    logic [CNT_W-1:0] col_cnt;
    logic [CNT_W-1:0] quad_cnt;

    int fails = 0;
    int queued = 0;
    int vertices_seen = 0;
    int wr_ptr = 0;
    int rd_ptr = 0;

    assign fail_count = fails;
    assign pending    = queued;

    task automatic report_mismatch(input string msg);
        fails++;
        $display("mismatch at vertex %0d: %s", vertices_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [POS_W-1:0] clip_pos(input logic [31:0] p);
        return (p > POS_LIMIT) ? '1 : p[POS_W-1:0];
    endfunction

    task automatic store_vertex(input vertex_t v);
        vertex_buf[wr_ptr % BUF_DEPTH] = v;
        wr_ptr++;
    endtask

    task automatic latch_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        case (idx)
            CFG_GLYPH_WIDTH:  glyph_w   = data[SIZE_W-1:0];
            CFG_GLYPH_HEIGHT: glyph_h   = data[SIZE_W-1:0];
            CFG_CHAR_OFFSET:  char_off  = data[CHAR_W-1:0];
            CFG_GRID_COLUMNS: grid_cols = data[GRID_W-1:0];
            CFG_GRID_ROWS:    grid_rows = data[GRID_W-1:0];
            CFG_UV_SCALE_U:   scale_u   = data[SCALE_W-1:0];
            CFG_UV_SCALE_V:   scale_v   = data[SCALE_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic layout_char(input logic [CHAR_W-1:0] ch, input logic restart);
        logic [GRID_W-1:0] cols;
        logic [CHAR_W-1:0] cell_idx;
        logic [GRID_W-1:0] acol;
        logic [GRID_W-1:0] arow_idx;
        logic [GRID_W-1:0] arow;
        logic              outside;
        logic              right;
        logic              bottom;
        logic [31:0]       base_x;
        logic [31:0]       base_y;
        logic [31:0]       tab_col;
        logic [31:0]       step_u;
        logic [31:0]       step_v;
        vertex_t           v;
        if (restart)
        begin
            line_cnt = '0;
            col_cnt  = '0;
            quad_cnt = '0;
        end
        case (ch)
            CHAR_NUL, CHAR_CR: ;
            CHAR_TAB:
            begin
                tab_col = 32'(col_cnt);
                tab_col = (tab_col / TAB_STOP + 1) * TAB_STOP;
                col_cnt = (tab_col > 32'hFFFF) ? '1 : tab_col[CNT_W-1:0];
            end
            CHAR_LF:
            begin
                line_cnt = bump(line_cnt);
                col_cnt  = '0;
            end
            default:
            begin
                cols = grid_cols;
                if (cols == '0)
                    cols = GRID_W'(1);
                cell_idx = ch - char_off;
                acol     = GRID_W'(cell_idx) % cols;
                arow_idx = GRID_W'(cell_idx) / cols;
                outside  = (arow_idx >= grid_rows);
                arow     = outside ? '0 : grid_rows - arow_idx - GRID_W'(1);
                base_x   = 32'(col_cnt) * 32'(glyph_w);
                base_y   = 32'(line_cnt) * 32'(glyph_h);
                for (int k = 0; k < 4; k++)
                begin
                    v.corner  = CORNER_W'(k);
                    right     = (v.corner == CORNER_TR) || (v.corner == CORNER_BR);
                    bottom    = (v.corner == CORNER_BR) || (v.corner == CORNER_BL);
                    v.pos_x   = clip_pos(base_x + (right ? 32'(glyph_w) : 32'd0));
                    v.pos_y   = clip_pos(base_y + (bottom ? 32'(glyph_h) : 32'd0));
                    step_u    = (32'(acol) + 32'(right)) * 32'(scale_u);
                    step_v    = (32'(arow) + 32'(bottom)) * 32'(scale_v);
                    v.tex_u   = step_u[TEX_W-1:0];
                    v.tex_v   = step_v[TEX_W-1:0];
                    v.quad    = quad_cnt;
                    v.outside = outside;
                    v.last    = (v.corner == CORNER_BL);
                    store_vertex(v);
                end
                quad_cnt = bump(quad_cnt);
                col_cnt  = bump(col_cnt);
            end
        endcase
    endtask

    task automatic check_vertex();
        vertex_t want;
        if (wr_ptr == rd_ptr)
        begin
            report_mismatch($sformatf("vertex with nothing expected, tdata %h", m_tdata));
        end
        else
        begin
            want = vertex_buf[rd_ptr % BUF_DEPTH];
            rd_ptr++;
            check_field("pos_x", 32'(m_tdata[POS_X_LSB +: POS_W]), 32'(want.pos_x));
            check_field("pos_y", 32'(m_tdata[POS_Y_LSB +: POS_W]), 32'(want.pos_y));
            check_field("tex_u", 32'(m_tdata[TEX_U_LSB +: TEX_W]), 32'(want.tex_u));
            check_field("tex_v", 32'(m_tdata[TEX_V_LSB +: TEX_W]), 32'(want.tex_v));
            check_field("corner", 32'(m_tdata[CORNER_LSB +: CORNER_W]), 32'(want.corner));
            check_field("quad_number", 32'(m_tdata[QUAD_LSB +: CNT_W]), 32'(want.quad));
            check_field("zero fill", 32'(m_tdata[M_TDATA_W-1:PACKED_W]), 32'd0);
            check_field("outside_atlas", 32'(m_tuser), 32'(want.outside));
            check_field("last", 32'(m_tlast), 32'(want.last));
        end
        vertices_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_w   = RST_GLYPH_WIDTH;
            glyph_h   = RST_GLYPH_HEIGHT;
            char_off  = RST_CHAR_OFFSET;
            grid_cols = RST_GRID_COLUMNS;
            grid_rows = RST_GRID_ROWS;
            scale_u   = RST_UV_SCALE_U;
            scale_v   = RST_UV_SCALE_V;
            line_cnt  = '0;
            col_cnt   = '0;
            quad_cnt  = '0;
            wr_ptr    = 0;
            rd_ptr    = 0;
            queued    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_vertex();
            if (cfg_we)
                latch_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                layout_char(s_tdata, s_tuser);
            queued = wr_ptr - rd_ptr;
        end
    end

endmodule

// File: sim/tb_bitmap_font_text_quad_generator.sv
// testbench top that drives text bytes and register writes into the text quad generator
`timescale 1ns / 1ps

module tb_bitmap_font_text_quad_generator;

    import bfq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 20;
    localparam int HOLD_PHASE     = 2;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    int fail_count;
    int pending;
    int idle_cycles;
    int rx_gap;
    bit hold_req;
    bit rx_steady;
    bit tx_gaps;

    always #(CLK_PERIOD / 2) clk = ~clk;

    bitmap_font_text_quad_generator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bfq_tb_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return CHAR_NUL;
        else if (roll < 10)
            return CHAR_TAB;
        else if (roll < 18)
            return CHAR_LF;
        else if (roll < 22)
            return CHAR_CR;
        else if (roll < 60)
            return CHAR_W'($urandom_range(33, 126));
        else
            return CHAR_W'($urandom_range(0, 255));
    endfunction

    // value in range for the register, junk above its width
    function automatic logic [CFG_DW-1:0] pick_reg(input logic [CFG_IW-1:0] idx);
        int roll;
        int width;
        int value;
        logic [31:0] junk;
        roll = $urandom_range(0, 99);
        case (idx)
            CFG_GLYPH_WIDTH, CFG_GLYPH_HEIGHT:
            begin
                width = SIZE_W;
                value = (roll < 5) ? 0 : (roll < 15) ? 1 : (roll < 30) ? 255
                      : $urandom_range(1, 255);
            end
            CFG_CHAR_OFFSET:
            begin
                width = CHAR_W;
                value = (roll < 10) ? 0 : (roll < 20) ? 255 : (roll < 50) ? 32
                      : $urandom_range(0, 255);
            end
            CFG_GRID_COLUMNS, CFG_GRID_ROWS:
            begin
                width = GRID_W;
                value = (roll < 5) ? 0 : (roll < 15) ? 1 : (roll < 25) ? 256
                      : (roll < 30) ? 511 : $urandom_range(2, 20);
            end
            default:
            begin
                width = SCALE_W;
                value = (roll < 10) ? 0 : (roll < 20) ? 262143 : $urandom_range(0, 262143);
            end
        endcase
        junk = $urandom;
        junk = (junk & ~((32'd1 << width) - 1)) | value;
        return junk[CFG_DW-1:0];
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic restart);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stop sending, let every vertex come out, then allow for bytes still in flight
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver: random stalls, steady stretches, and one long hold on request
    initial
    begin
        rx_gap = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady)
                    rx_gap = pick_gap();
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("bitmap_font_text_quad_generator test failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        hold_req  = 1'b0;
        rx_steady = 1'b0;
        tx_gaps   = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes of the byte, every control byte, restarts
        send_char(" ", 1'b1);
        send_char("A", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(CHAR_NUL, 1'b0);
        send_char(CHAR_CR, 1'b0);
        send_char(CHAR_TAB, 1'b0);
        send_char("x", 1'b0);
        send_char(CHAR_LF, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(8'h1F, 1'b0);
        send_char(CHAR_TAB, 1'b0);
        send_char(CHAR_TAB, 1'b0);
        send_char("B", 1'b1);
        send_char(CHAR_LF, 1'b1);
        send_char("~", 1'b0);
        settle();

        // zero grid and zero glyph size
        write_reg(CFG_GRID_COLUMNS, '0);
        write_reg(CFG_GRID_ROWS, '0);
        write_reg(CFG_GLYPH_WIDTH, '0);
        write_reg(CFG_GLYPH_HEIGHT, '0);
        send_char("A", 1'b1);
        send_char("~", 1'b0);
        send_char(CHAR_LF, 1'b0);
        send_char("z", 1'b0);
        settle();

        // widest grid, largest scales and sizes, offset zero
        write_reg(CFG_GRID_COLUMNS, 18'h3FFFF);
        write_reg(CFG_GRID_ROWS, 18'h3FFFF);
        write_reg(CFG_GLYPH_WIDTH, 18'h3FFFF);
        write_reg(CFG_GLYPH_HEIGHT, 18'h3FFFF);
        write_reg(CFG_CHAR_OFFSET, 18'h3FF00);
        write_reg(CFG_UV_SCALE_U, 18'h3FFFF);
        write_reg(CFG_UV_SCALE_V, 18'h3FFFF);
        write_reg(CFG_UNUSED, 18'h00001);
        send_char(8'hFF, 1'b1);
        send_char(8'h0B, 1'b0);
        send_char("Q", 1'b0);
        settle();

        // one column, few rows, highest offset: cells both inside and beyond the atlas
        write_reg(CFG_GRID_COLUMNS, 18'd1);
        write_reg(CFG_GRID_ROWS, 18'd3);
        write_reg(CFG_CHAR_OFFSET, 18'd255);
        send_char(8'hFF, 1'b1);
        send_char(8'h01, 1'b0);
        send_char("M", 1'b0);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int r = CFG_GLYPH_WIDTH; r <= CFG_UV_SCALE_V; r++)
                write_reg(CFG_IW'(r), pick_reg(CFG_IW'(r)));
            rx_steady = ($urandom_range(0, 3) == 0);
            tx_gaps   = (phase != HOLD_PHASE) && ($urandom_range(0, 3) != 0);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            send_char(pick_char(), 1'b1);
            for (int i = 1; i < PHASE_ITEMS; i++)
                send_char(pick_char(), ($urandom_range(0, 19) == 0));
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("bitmap_font_text_quad_generator test passed");
        else
            $display("bitmap_font_text_quad_generator test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bfq_pkg.sv
rtl/bfq_div.sv
rtl/bfq_dp.sv
rtl/bfq_ctrl.sv
rtl/bitmap_font_text_quad_generator.sv
rtl/bfq_checker.sv
sim/bfq_checker.sv
sim/tb_bitmap_font_text_quad_generator.sv
